### sv/assert_macros.svh
// Assertion macros shared by the box transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define AAT_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("aat: implication check failed");

// Next-cycle implication, checked out of reset
`define AAT_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("aat: next-cycle check failed");

`endif

### sv/aat_pkg.sv
// Types, constants and register codes of the box affine transform.
`default_nettype none

package aat_pkg;

    localparam int AXES       = 3;
    localparam int COORD_W    = 24;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 12;
    localparam int PROD_W     = COORD_W + COEF_W;
    localparam int SUM_W      = PROD_W + 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = AXES * COEF_W;
    localparam int ROUND_HALF = 1 << (FRAC_W - 1);
    localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
    localparam int COORD_MIN  = -(1 << (COORD_W - 1));

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    // element 0 sits in the low bits and multiplies x
    typedef coef_t [AXES-1:0]          row_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_ROW_SCALE = 3'd0,
        CFG_Y_ROW_SCALE = 3'd1,
        CFG_Z_ROW_SCALE = 3'd2,
        CFG_X_OFFSET    = 3'd3,
        CFG_Y_OFFSET    = 3'd4,
        CFG_Z_OFFSET    = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    typedef struct packed {
        coord_t out_min_x;
        coord_t out_min_y;
        coord_t out_min_z;
        coord_t out_max_x;
        coord_t out_max_y;
        coord_t out_max_z;
    } bounds_t;

    // Active transform: row r gives output axis r
    typedef struct packed {
        row_t   [AXES-1:0] row;
        coord_t [AXES-1:0] offset;
    } xform_t;

    // Per-term extremes over the two corner values, [row][column]
    typedef struct packed {
        prod_t [AXES-1:0][AXES-1:0] lo;
        prod_t [AXES-1:0][AXES-1:0] hi;
    } span_t;

    localparam row_t ROW_X_RESET = row_t'(48'h000000001000);
    localparam row_t ROW_Y_RESET = row_t'(48'h000010000000);
    localparam row_t ROW_Z_RESET = row_t'(48'h100000000000);

endpackage

`default_nettype wire

### sv/aat_if.sv
// Channel interfaces: box requests, bound results and register writes.
`default_nettype none

interface aat_box_if;
    logic          valid;
    logic          ready;
    aat_pkg::box_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

interface aat_bounds_if;
    logic             valid;
    logic             ready;
    aat_pkg::bounds_t data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

interface aat_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [aat_pkg::CFG_IDX_W-1:0]    index;
    logic [aat_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/aabb_affine_transform.sv
// An accepted box request moves through four register stages (products, term min/max,
// row sums, floor and saturate) to its bounds on the output register; each stage holds
// one request and moves on handshake. Throughput: one box per cycle while not stalled.
// A stalled output holds its result while earlier stages keep filling bubbles.
// Reset (rst_n low, asynchronous) clears all valid bits and loads the identity map.
`default_nettype none

module aabb_affine_transform (
    input  wire logic   clk,
    input  wire logic   rst_n,
    aat_cfg_if.sink     cfg,
    aat_box_if.sink     box,
    aat_bounds_if.source bounds
);

    aat_pkg::xform_t xform;
    aat_pkg::span_t  span;
    logic            span_valid;
    logic            span_ready;

    // configuration registers
    aat_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .xform (xform)
    );

    // products and per-term extremes
    aat_term u_term (
        .clk        (clk),
        .rst_n      (rst_n),
        .xform      (xform),
        .box_valid  (box.valid),
        .box_ready  (box.ready),
        .box        (box.data),
        .span_valid (span_valid),
        .span_ready (span_ready),
        .span       (span)
    );

    // sums, rounding and saturation
    aat_reduce u_reduce (
        .clk          (clk),
        .rst_n        (rst_n),
        .xform        (xform),
        .span_valid   (span_valid),
        .span_ready   (span_ready),
        .span         (span),
        .bounds_valid (bounds.valid),
        .bounds_ready (bounds.ready),
        .bounds       (bounds.data)
    );

endmodule

`default_nettype wire

### sv/aat_cfg.sv
// Register file holding the affine matrix rows and offsets.
`default_nettype none
`include "assert_macros.svh"

module aat_cfg (
    input  wire logic            clk,
    input  wire logic            rst_n,
    aat_cfg_if.sink              cfg,
    output aat_pkg::xform_t      xform
);

    aat_pkg::xform_t xform_reg;
    aat_pkg::xform_t xform_next;

    // writes never stall
    assign cfg.ready = 1'b1;
    assign xform     = xform_reg;

    // register decode, unknown indexes dropped
    always_comb
    begin
        xform_next = xform_reg;
        if (cfg.valid)
        begin
            unique case (aat_pkg::cfg_idx_t'(cfg.index))
                aat_pkg::CFG_X_ROW_SCALE: xform_next.row[0]    = aat_pkg::row_t'(cfg.data);
                aat_pkg::CFG_Y_ROW_SCALE: xform_next.row[1]    = aat_pkg::row_t'(cfg.data);
                aat_pkg::CFG_Z_ROW_SCALE: xform_next.row[2]    = aat_pkg::row_t'(cfg.data);
                aat_pkg::CFG_X_OFFSET:
                    xform_next.offset[0] = aat_pkg::coord_t'(cfg.data[aat_pkg::COORD_W-1:0]);
                aat_pkg::CFG_Y_OFFSET:
                    xform_next.offset[1] = aat_pkg::coord_t'(cfg.data[aat_pkg::COORD_W-1:0]);
                aat_pkg::CFG_Z_OFFSET:
                    xform_next.offset[2] = aat_pkg::coord_t'(cfg.data[aat_pkg::COORD_W-1:0]);
                default: ;
            endcase
        end
    end

    // identity map out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xform_reg.row[0]    <= aat_pkg::ROW_X_RESET;
            xform_reg.row[1]    <= aat_pkg::ROW_Y_RESET;
            xform_reg.row[2]    <= aat_pkg::ROW_Z_RESET;
            xform_reg.offset[0] <= '0;
            xform_reg.offset[1] <= '0;
            xform_reg.offset[2] <= '0;
        end
        else
        begin
            xform_reg <= xform_next;
        end
    end

    `AAT_ASSERT_NEXT(a_x_offset_write, clk, rst_n, cfg.valid && cfg.ready && cfg.index == aat_pkg::CFG_X_OFFSET, xform.offset[0] == $past(cfg.data[aat_pkg::COORD_W-1:0]))
    `AAT_ASSERT_NEXT(a_x_row_write, clk, rst_n, cfg.valid && cfg.ready && cfg.index == aat_pkg::CFG_X_ROW_SCALE, xform.row[0] == $past(cfg.data))

endmodule

`default_nettype wire

### sv/aat_term.sv
// Product stage and per-term min/max selection over the two corner values.
`default_nettype none
`include "assert_macros.svh"

module aat_term (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire aat_pkg::xform_t  xform,
    input  wire logic             box_valid,
    output logic                  box_ready,
    input  wire aat_pkg::box_t    box,
    output logic                  span_valid,
    input  wire logic             span_ready,
    output aat_pkg::span_t        span
);

    aat_pkg::coord_t lo_coord [aat_pkg::AXES];
    aat_pkg::coord_t hi_coord [aat_pkg::AXES];

    aat_pkg::prod_t [aat_pkg::AXES-1:0][aat_pkg::AXES-1:0] plo_reg, plo_next;
    aat_pkg::prod_t [aat_pkg::AXES-1:0][aat_pkg::AXES-1:0] phi_reg, phi_next;
    aat_pkg::span_t span_reg, span_next;

    logic a_valid_reg;
    logic b_valid_reg;
    logic a_adv;
    logic b_adv;

    // stage moves when empty or when the next one takes its contents
    assign b_adv      = !b_valid_reg || span_ready;
    assign a_adv      = !a_valid_reg || b_adv;
    assign box_ready  = a_adv;
    assign span_valid = b_valid_reg;
    assign span       = span_reg;

    assign lo_coord[0] = box.min_x;
    assign lo_coord[1] = box.min_y;
    assign lo_coord[2] = box.min_z;
    assign hi_coord[0] = box.max_x;
    assign hi_coord[1] = box.max_y;
    assign hi_coord[2] = box.max_z;

    // stage A: coefficient times both corner values, nine pairs
    always_comb
    begin
        for (int r = 0; r < aat_pkg::AXES; r++)
        begin
            for (int k = 0; k < aat_pkg::AXES; k++)
            begin
                plo_next[r][k] = $signed(xform.row[r][k]) * lo_coord[k];
                phi_next[r][k] = $signed(xform.row[r][k]) * hi_coord[k];
            end
        end
    end

    // stage B: each term is separable, so its extremes bound every corner
    always_comb
    begin
        for (int r = 0; r < aat_pkg::AXES; r++)
        begin
            for (int k = 0; k < aat_pkg::AXES; k++)
            begin
                if (plo_reg[r][k] <= phi_reg[r][k])
                begin
                    span_next.lo[r][k] = plo_reg[r][k];
                    span_next.hi[r][k] = phi_reg[r][k];
                end
                else
                begin
                    span_next.lo[r][k] = phi_reg[r][k];
                    span_next.hi[r][k] = plo_reg[r][k];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= box_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (b_adv)
        begin
            span_reg <= span_next;
        end
    end

    `AAT_ASSERT_NEXT(a_span_hold, clk, rst_n, span_valid && !span_ready, span_valid && $stable(span))
    `AAT_ASSERT_IMP(a_span_order, clk, rst_n, span_valid, span.lo[0][0] <= span.hi[0][0] && span.lo[1][1] <= span.hi[1][1] && span.lo[2][2] <= span.hi[2][2])

endmodule

`default_nettype wire

### sv/aat_reduce.sv
// Row sums with offset and rounding, then floor shift and saturation.
`default_nettype none
`include "assert_macros.svh"

module aat_reduce (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire aat_pkg::xform_t  xform,
    input  wire logic             span_valid,
    output logic                  span_ready,
    input  wire aat_pkg::span_t   span,
    output logic                  bounds_valid,
    input  wire logic             bounds_ready,
    output aat_pkg::bounds_t      bounds
);

    aat_pkg::sum_t [aat_pkg::AXES-1:0] sum_lo_reg, sum_lo_next;
    aat_pkg::sum_t [aat_pkg::AXES-1:0] sum_hi_reg, sum_hi_next;
    aat_pkg::bounds_t bounds_reg, bounds_next;

    logic c_valid_reg;
    logic d_valid_reg;
    logic c_adv;
    logic d_adv;

    // drop the fraction (floor) and clamp to the coordinate range
    function automatic aat_pkg::coord_t sat(input aat_pkg::sum_t a);
        logic signed [aat_pkg::SUM_W-aat_pkg::FRAC_W-1:0] q;
        q = $signed(a[aat_pkg::SUM_W-1:aat_pkg::FRAC_W]);
        if (q > aat_pkg::COORD_MAX)
            return aat_pkg::coord_t'(aat_pkg::COORD_MAX);
        else if (q < aat_pkg::COORD_MIN)
            return aat_pkg::coord_t'(aat_pkg::COORD_MIN);
        else
            return aat_pkg::coord_t'(q);
    endfunction

    assign d_adv        = !d_valid_reg || bounds_ready;
    assign c_adv        = !c_valid_reg || d_adv;
    assign span_ready   = c_adv;
    assign bounds_valid = d_valid_reg;
    assign bounds       = bounds_reg;

    // stage C: three terms, offset in product scale, half-unit rounding bias
    always_comb
    begin
        for (int r = 0; r < aat_pkg::AXES; r++)
        begin
            sum_lo_next[r] = aat_pkg::sum_t'(span.lo[r][0]) + aat_pkg::sum_t'(span.lo[r][1])
                           + aat_pkg::sum_t'(span.lo[r][2])
                           + (aat_pkg::sum_t'(xform.offset[r]) <<< aat_pkg::FRAC_W)
                           + aat_pkg::sum_t'(aat_pkg::ROUND_HALF);
            sum_hi_next[r] = aat_pkg::sum_t'(span.hi[r][0]) + aat_pkg::sum_t'(span.hi[r][1])
                           + aat_pkg::sum_t'(span.hi[r][2])
                           + (aat_pkg::sum_t'(xform.offset[r]) <<< aat_pkg::FRAC_W)
                           + aat_pkg::sum_t'(aat_pkg::ROUND_HALF);
        end
    end

    // stage D: output register
    always_comb
    begin
        bounds_next.out_min_x = sat(sum_lo_reg[0]);
        bounds_next.out_min_y = sat(sum_lo_reg[1]);
        bounds_next.out_min_z = sat(sum_lo_reg[2]);
        bounds_next.out_max_x = sat(sum_hi_reg[0]);
        bounds_next.out_max_y = sat(sum_hi_reg[1]);
        bounds_next.out_max_z = sat(sum_hi_reg[2]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_adv)
            begin
                c_valid_reg <= span_valid;
            end
            if (d_adv)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (c_adv)
        begin
            sum_lo_reg <= sum_lo_next;
            sum_hi_reg <= sum_hi_next;
        end
        if (d_adv)
        begin
            bounds_reg <= bounds_next;
        end
    end

    `AAT_ASSERT_IMP(a_sum_order, clk, rst_n, c_valid_reg, sum_lo_reg[0] <= sum_hi_reg[0] && sum_lo_reg[1] <= sum_hi_reg[1] && sum_lo_reg[2] <= sum_hi_reg[2])
    `AAT_ASSERT_IMP(a_bounds_order, clk, rst_n, bounds_valid, bounds.out_min_x <= bounds.out_max_x && bounds.out_min_y <= bounds.out_max_y && bounds.out_min_z <= bounds.out_max_z)

endmodule

`default_nettype wire

### tb/bounds_checker.sv
`timescale 1ns / 1ps
// Bounds checker: predicts each transformed box and compares it with the block's results.
module bounds_checker
    import aat_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    aat_cfg_if    cfg_mon,
    aat_box_if    box_mon,
    aat_bounds_if bounds_mon,
    output int    fail_count,
    output int    outstanding
);

    // Current matrix and offsets as seen through accepted register writes
    xform_t  active_xform;
    // Bounds predicted for accepted box requests, oldest first
    bounds_t pending_bounds[$];

    // Field order follows the packed bounds struct, lowest bits first
    string field_names[2*AXES] = '{"out_max_z", "out_max_y", "out_max_x",
                                   "out_min_z", "out_min_y", "out_min_x"};

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    task automatic report_fault(input string msg);
        $display("[%0t] bounds check: %s", $time, msg);
        fail_count++;
    endtask

    // One output axis of one corner: exact sum, round half up, floor, saturate
    function automatic longint map_axis(input row_t r, input coord_t off,
                                        input coord_t x, input coord_t y, input coord_t z);
        longint acc;
        acc = longint'($signed(r[0])) * longint'($signed(x))
            + longint'($signed(r[1])) * longint'($signed(y))
            + longint'($signed(r[2])) * longint'($signed(z))
            + longint'($signed(off)) * (longint'(1) <<< FRAC_W)
            + longint'(ROUND_HALF);
        acc = acc >>> FRAC_W;
        if (acc > longint'(COORD_MAX))
            acc = longint'(COORD_MAX);
        else if (acc < longint'(COORD_MIN))
            acc = longint'(COORD_MIN);
        return acc;
    endfunction

    // Map all eight corners and keep the per-axis extremes
    function automatic bounds_t transform_box(input box_t b, input xform_t m);
        coord_t  lo[AXES];
        coord_t  hi[AXES];
        coord_t  pt[AXES];
        longint  mn[AXES];
        longint  mx[AXES];
        longint  t;
        bounds_t r;
        lo[0] = b.min_x;
        lo[1] = b.min_y;
        lo[2] = b.min_z;
        hi[0] = b.max_x;
        hi[1] = b.max_y;
        hi[2] = b.max_z;
        for (int c = 0; c < (1 << AXES); c++) begin
            for (int k = 0; k < AXES; k++)
                pt[k] = c[k] ? hi[k] : lo[k];
            for (int k = 0; k < AXES; k++) begin
                t = map_axis(m.row[k], m.offset[k], pt[0], pt[1], pt[2]);
                if (c == 0 || t < mn[k])
                    mn[k] = t;
                if (c == 0 || t > mx[k])
                    mx[k] = t;
            end
        end
        r.out_min_x = coord_t'(mn[0]);
        r.out_min_y = coord_t'(mn[1]);
        r.out_min_z = coord_t'(mn[2]);
        r.out_max_x = coord_t'(mx[0]);
        r.out_max_y = coord_t'(mx[1]);
        r.out_max_z = coord_t'(mx[2]);
        return r;
    endfunction

    // Watch all three channels on each edge
    always @(posedge clk or negedge rst_n)
    begin
        bounds_t want;
        bounds_t got;
        if (!rst_n)
        begin
            active_xform.row[0]    = ROW_X_RESET;
            active_xform.row[1]    = ROW_Y_RESET;
            active_xform.row[2]    = ROW_Z_RESET;
            active_xform.offset[0] = '0;
            active_xform.offset[1] = '0;
            active_xform.offset[2] = '0;
            pending_bounds.delete();
        end
        else
        begin
            // new request: predict with the map in force before this edge
            if (box_mon.valid && box_mon.ready)
                pending_bounds.push_back(transform_box(box_mon.data, active_xform));

            // result: compare against the oldest prediction
            if (bounds_mon.valid && bounds_mon.ready)
            begin
                got = bounds_mon.data;
                if (pending_bounds.size() == 0)
                    report_fault($sformatf("unexpected result %h", got));
                else
                begin
                    want = pending_bounds.pop_front();
                    for (int f = 0; f < 2 * AXES; f++)
                        if (got[f*COORD_W +: COORD_W] !== want[f*COORD_W +: COORD_W])
                            report_fault($sformatf("%s got %0d expected %0d", field_names[f],
                                $signed(got[f*COORD_W +: COORD_W]),
                                $signed(want[f*COORD_W +: COORD_W])));
                end
            end

            // register write; unknown indexes change nothing
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_idx_t'(cfg_mon.index))
                    CFG_X_ROW_SCALE: active_xform.row[0] = row_t'(cfg_mon.data);
                    CFG_Y_ROW_SCALE: active_xform.row[1] = row_t'(cfg_mon.data);
                    CFG_Z_ROW_SCALE: active_xform.row[2] = row_t'(cfg_mon.data);
                    CFG_X_OFFSET:    active_xform.offset[0] = coord_t'(cfg_mon.data[COORD_W-1:0]);
                    CFG_Y_OFFSET:    active_xform.offset[1] = coord_t'(cfg_mon.data[COORD_W-1:0]);
                    CFG_Z_OFFSET:    active_xform.offset[2] = coord_t'(cfg_mon.data[COORD_W-1:0]);
                    default:         ;
                endcase
            end
        end
        outstanding = pending_bounds.size();
    end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the box affine transform: stimulus, receiver stalls and verdict.
module tb;
    import aat_pkg::*;

    localparam int LATENCY         = 4;
    localparam int DRAIN_CYCLES    = 2 * LATENCY;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_PERIOD     = 500;
    localparam int HOLD_CYCLES     = 80;
    localparam int RANDOM_PHASES   = 12;
    localparam int BOXES_PER_PHASE = 120;

    localparam coord_t CMAX = coord_t'(COORD_MAX);
    localparam coord_t CMIN = coord_t'(COORD_MIN);
    localparam coord_t ONE  = coord_t'(256);    // 1.0 in Q16.8

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   outstanding;
    int   burst_left = 0;

    aat_cfg_if    cfg_ch ();
    aat_box_if    box_ch ();
    aat_bounds_if bounds_ch ();

    aabb_affine_transform uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .box    (box_ch),
        .bounds (bounds_ch)
    );

    bounds_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_mon     (cfg_ch),
        .box_mon     (box_ch),
        .bounds_mon  (bounds_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic coord_t rand_coord(input int span);
        return coord_t'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic coord_t extreme_coord();
        case ($urandom_range(0, 4))
            0:       return CMAX;
            1:       return CMIN;
            2:       return coord_t'(0);
            3:       return coord_t'(-1);
            default: return coord_t'(1);
        endcase
    endfunction

    function automatic box_t make_box(input coord_t ax, input coord_t ay, input coord_t az,
                                      input coord_t bx, input coord_t by, input coord_t bz);
        box_t b;
        b.min_x = ax;
        b.min_y = ay;
        b.min_z = az;
        b.max_x = bx;
        b.max_y = by;
        b.max_z = bz;
        return b;
    endfunction

    // Mostly ordered boxes of moderate size; some raw, extreme, point or inverted ones
    function automatic box_t random_box();
        int     style;
        coord_t lo[AXES];
        coord_t hi[AXES];
        coord_t ctr;
        coord_t ext;
        coord_t tmp;
        style = $urandom_range(0, 9);
        for (int k = 0; k < AXES; k++)
        begin
            case (style)
                0, 1:    begin
                    lo[k] = coord_t'($urandom);
                    hi[k] = coord_t'($urandom);
                end
                2:       begin
                    lo[k] = extreme_coord();
                    hi[k] = extreme_coord();
                end
                3:       begin
                    lo[k] = rand_coord(1 << 16);
                    hi[k] = lo[k];
                end
                default: begin
                    ctr   = rand_coord(1 << 20);
                    ext   = coord_t'($urandom_range(0, 1 << 14));
                    lo[k] = ctr - ext;
                    hi[k] = ctr + ext;
                end
            endcase
            // inverted box: minimum above maximum
            if (style == 4)
            begin
                tmp   = lo[k];
                lo[k] = hi[k];
                hi[k] = tmp;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    // Raw, edge-valued or modest (|c| <= 1.0) coefficient rows
    function automatic row_t random_row();
        row_t r;
        case ($urandom_range(0, 3))
            0: r = row_t'({16'($urandom), 32'($urandom)});
            1: for (int k = 0; k < AXES; k++)
                case ($urandom_range(0, 5))
                    0:       r[k] = coef_t'(16'h7FFF);
                    1:       r[k] = coef_t'(16'h8000);
                    2:       r[k] = coef_t'(16'h0000);
                    3:       r[k] = coef_t'(16'h1000);   // +1.0
                    4:       r[k] = coef_t'(16'hF000);   // -1.0
                    default: r[k] = coef_t'(16'h0800);   // +0.5
                endcase
            default: for (int k = 0; k < AXES; k++)
                r[k] = coef_t'(int'($urandom_range(0, 8192)) - 4096);
        endcase
        return r;
    endfunction

    function automatic coord_t random_offset();
        case ($urandom_range(0, 2))
            0:       return coord_t'($urandom);
            1:       return extreme_coord();
            default: return rand_coord(1 << 16);
        endcase
    endfunction

    // Register write; valid stays high so back-to-back writes need no toggle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Full map load; offsets carry junk above bit 23, plus one write to an unused index
    task automatic load_xform(input row_t rx, input row_t ry, input row_t rz,
                              input coord_t ox, input coord_t oy, input coord_t oz);
        write_reg(CFG_X_ROW_SCALE, rx);
        write_reg(CFG_Y_ROW_SCALE, ry);
        write_reg(CFG_Z_ROW_SCALE, rz);
        write_reg(CFG_X_OFFSET, {24'($urandom), ox});
        write_reg(CFG_Y_OFFSET, {24'($urandom), oy});
        write_reg(CFG_Z_OFFSET, {24'($urandom), oz});
        write_reg(CFG_IDX_W'($urandom_range(CFG_Z_OFFSET + 1, (1 << CFG_IDX_W) - 1)),
                  {16'($urandom), 32'($urandom)});
        cfg_ch.valid <= 1'b0;
    endtask

    // Box request inside a burst; a random gap, possibly empty, is inserted when the burst runs out
    task automatic send_box(input box_t b);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                box_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
        end
        box_ch.valid <= 1'b1;
        box_ch.data  <= b;
        do @(posedge clk); while (!box_ch.ready);
        burst_left--;
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain();
        box_ch.valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Result side: random ready duty per segment, periodic long hold-off
    initial
    begin
        int pct;
        int seg_len;
        int rcv_cycles;
        bounds_ch.ready = 1'b0;
        rcv_cycles      = 0;
        wait (rst_n);
        forever
        begin
            seg_len = $urandom_range(8, 40);
            case ($urandom_range(0, 3))
                0:       pct = 100;
                1:       pct = 80;
                2:       pct = 50;
                default: pct = 20;
            endcase
            repeat (seg_len)
            begin
                @(posedge clk);
                rcv_cycles++;
                if (rcv_cycles % HOLD_PERIOD == 0)
                begin
                    // hold off long enough for the pipeline to back up into the input
                    bounds_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                    bounds_ch.ready <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    // Watchdog: too long without any handshake on any channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cfg_ch.valid && cfg_ch.ready) || (box_ch.valid && box_ch.ready) ||
                (bounds_ch.valid && bounds_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Main sequence
    initial
    begin
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_X_ROW_SCALE;
        cfg_ch.data  = '0;
        box_ch.valid = 1'b0;
        box_ch.data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity map straight out of reset
        send_box(make_box('0, '0, '0, '0, '0, '0));
        send_box(make_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_box(make_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_box(make_box(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_box(make_box(coord_t'(3 * ONE), coord_t'(2 * ONE), ONE,
                          -ONE, coord_t'(-2 * ONE), coord_t'(-3 * ONE)));
        send_box(make_box(24'h555555, 24'hAAAAAA, 24'h555555,
                          24'hAAAAAA, 24'h555555, 24'hAAAAAA));
        send_box(make_box(coord_t'(-1), coord_t'(-1), coord_t'(-1),
                          coord_t'(-1), coord_t'(-1), coord_t'(-1)));
        drain();

        // largest positive coefficients and offsets: saturation both ways
        load_xform(row_t'({AXES{16'h7FFF}}), row_t'({AXES{16'h7FFF}}),
                   row_t'({AXES{16'h7FFF}}), CMAX, CMAX, CMAX);
        send_box(make_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        drain();

        // most negative coefficients and offsets
        load_xform(row_t'({AXES{16'h8000}}), row_t'({AXES{16'h8000}}),
                   row_t'({AXES{16'h8000}}), CMIN, CMIN, CMIN);
        send_box(make_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
        send_box(make_box(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        drain();

        // zero matrix: every corner lands on the offset
        load_xform(row_t'('0), row_t'('0), row_t'('0),
                   random_offset(), random_offset(), random_offset());
        send_box(random_box());
        send_box(make_box(CMAX, ONE, CMAX, CMIN, -ONE, CMIN));
        drain();

        // half-LSB products: +0.5 rounds up, -0.5 rounds to zero
        load_xform(row_t'({16'h0000, 16'h0000, 16'h0800}),
                   row_t'({16'h0000, 16'hF800, 16'h0000}),
                   ROW_Z_RESET, coord_t'(0), coord_t'(0), coord_t'(0));
        send_box(make_box(coord_t'(1), coord_t'(1), coord_t'(-1),
                          coord_t'(-1), coord_t'(-1), coord_t'(1)));
        send_box(make_box(coord_t'(3), coord_t'(-3), CMAX,
                          coord_t'(-3), coord_t'(3), CMIN));
        drain();

        // random maps, each with a stream of random boxes
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            load_xform(random_row(), random_row(), random_row(),
                       random_offset(), random_offset(), random_offset());
            repeat (BOXES_PER_PHASE) send_box(random_box());
            drain();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
+incdir+sv
sv/aat_pkg.sv
sv/aat_if.sv
sv/aat_cfg.sv
sv/aat_term.sv
sv/aat_reduce.sv
sv/aabb_affine_transform.sv
tb/bounds_checker.sv
tb/tb.sv
